[hw/rtl/bf_pkg.sv]
// Blowfish engine package: item types, kind codes, pi subkey constants.
// No dependencies.
package bf_pkg;

    localparam int ROUNDS        = 16;
    localparam int KEY_MAX_BYTES = 56;
    localparam int SUBKEY_COUNT  = ROUNDS + 2;
    localparam int SK_W          = $clog2(SUBKEY_COUNT);
    localparam int KP_W          = $clog2(KEY_MAX_BYTES);
    localparam int BOX_WORDS     = 1024;

    localparam logic [2:0] KIND_LOAD_SUBKEY = 3'd0;
    localparam logic [2:0] KIND_LOAD_BOX    = 3'd1;
    localparam logic [2:0] KIND_KEY_BYTE    = 3'd2;
    localparam logic [2:0] KIND_EXPAND      = 3'd3;
    localparam logic [2:0] KIND_BLOCK       = 3'd4;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_IDX = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic        decrypt_mode;
        logic [9:0]  index;
        logic [31:0] table_word;
        logic [7:0]  key_byte;
        logic [5:0]  key_length;
        logic [31:0] left_in;
        logic [31:0] right_in;
    } bf_in_t;

    typedef struct packed {
        logic [31:0] left_out;
        logic [31:0] right_out;
        logic [1:0]  status;
    } bf_out_t;

    function automatic logic [31:0] pi_word(input logic [4:0] i);
        logic [31:0] w;
        case (i)
            5'd0:  w = 32'h243F6A88;
            5'd1:  w = 32'h85A308D3;
            5'd2:  w = 32'h13198A2E;
            5'd3:  w = 32'h03707344;
            5'd4:  w = 32'hA4093822;
            5'd5:  w = 32'h299F31D0;
            5'd6:  w = 32'h082EFA98;
            5'd7:  w = 32'hEC4E6C89;
            5'd8:  w = 32'h452821E6;
            5'd9:  w = 32'h38D01377;
            5'd10: w = 32'hBE5466CF;
            5'd11: w = 32'h34E90C6C;
            5'd12: w = 32'hC0AC29B7;
            5'd13: w = 32'hC97C50DD;
            5'd14: w = 32'h3F84D5B5;
            5'd15: w = 32'hB5470917;
            5'd16: w = 32'h9216D5D9;
            5'd17: w = 32'h8979FB1B;
            default: w = 32'h0;
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/bf_sbox.sv]
// One 256-word substitution box memory, registered read, with one write
// port that the clearing sweep also uses. Depends on bf_pkg.
module bf_sbox
    import bf_pkg::*;
(
    input  logic        clk,
    input  logic        we,
    input  logic [7:0]  waddr,
    input  logic [31:0] wdata,
    input  logic [7:0]  raddr,
    output logic [31:0] rdata
);
    logic [31:0] mem [256];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hw/rtl/blowfish_cipher_engine.sv]
// Blowfish engine top level: sequencer, subkey registers, key store, four
// box memories and one shared round unit. Depends on bf_pkg, bf_sbox.
//
//  channel | signals                         | direction
//  in      | in_valid, in_ready, in_data     | item into engine
//  out     | out_valid, out_ready, out_data  | result item out
//
// After reset a clearing pass zeroes the boxes and key store, in_ready low.
// A block runs each Feistel round as a box read, then a combine, and ends
// with a final whitening step and an output step; loads finish on accept.
// Key expansion runs 72 key XOR steps (one key byte each) then 521 block
// encryptions whose results refill the subkeys and boxes. The box read port
// sets the round rate. in_ready is low while an item is at work or its
// result is still waiting.
module blowfish_cipher_engine
    import bf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  bf_in_t  in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output bf_out_t out_data
);
    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_XOR   = 9'b000000100,
        S_RREAD = 9'b000001000,
        S_RCOMB = 9'b000010000,
        S_FINAL = 9'b000100000,
        S_STORE = 9'b001000000,
        S_STORE2= 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t      state_reg, state_next;
    bf_in_t      item_reg;
    logic [31:0] subkey_reg [SUBKEY_COUNT];
    logic [7:0]  key_mem [KEY_MAX_BYTES];
    logic [7:0]  key_rd_reg;
    logic [31:0] l_reg, r_reg;
    logic [4:0]  round_reg;
    logic [SK_W-1:0] ski_reg;
    logic [1:0]  kb_reg;
    logic [KP_W-1:0] pos_reg;
    logic [KP_W-1:0] pos_next;
    logic [KP_W-1:0] key_ra;
    logic [31:0] w_reg;
    logic [10:0] fill_reg;  // subkeys 0..17 then boxes 18..
    logic        expand_reg;
    logic [7:0]  clr_reg;
    bf_out_t     out_reg;
    logic        out_valid_reg;

    logic [31:0] box_rd [4];
    logic        box_we [4];
    logic [7:0]  box_wa [4];
    logic [31:0] box_wd [4];
    logic [7:0]  box_ra [4];

    for (genvar g = 0; g < 4; g++)
    begin : g_box
        bf_sbox u_box (
            .clk(clk), .we(box_we[g]), .waddr(box_wa[g]), .wdata(box_wd[g]),
            .raddr(box_ra[g]), .rdata(box_rd[g])
        );
    end

    // round subkey index
    logic [SK_W-1:0] rk;
    always_comb
    begin
        if (item_reg.decrypt_mode && !expand_reg)
            rk = SK_W'(SUBKEY_COUNT - 1) - SK_W'(round_reg);
        else
            rk = SK_W'(round_reg);
    end

    logic [31:0] lx;
    logic [31:0] f_val;
    assign lx = l_reg ^ subkey_reg[rk];
    assign f_val = ((box_rd[0] + box_rd[1]) ^ box_rd[2]) + box_rd[3];

    logic [9:0] box_fill_idx;
    assign box_fill_idx = 10'(fill_reg - 11'(SUBKEY_COUNT));

    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            box_ra[b] = lx[31-8*b -: 8];
            box_we[b] = 1'b0;
            box_wa[b] = 8'h0;
            box_wd[b] = 32'h0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                for (int b = 0; b < 4; b++)
                begin
                    box_we[b] = 1'b1;
                    box_wa[b] = clr_reg;
                end
            end
            S_IDLE:
            begin
                if (in_valid && in_ready && in_data.kind == KIND_LOAD_BOX)
                begin
                    box_we[in_data.index[9:8]] = 1'b1;
                    box_wa[in_data.index[9:8]] = in_data.index[7:0];
                    box_wd[in_data.index[9:8]] = in_data.table_word;
                end
            end
            S_STORE:
            begin
                if (fill_reg >= 11'(SUBKEY_COUNT))
                begin
                    box_we[box_fill_idx[9:8]] = 1'b1;
                    box_wa[box_fill_idx[9:8]] = box_fill_idx[7:0];
                    box_wd[box_fill_idx[9:8]] = l_reg;
                end
            end
            S_STORE2:
            begin
                if (fill_reg >= 11'(SUBKEY_COUNT))
                begin
                    box_we[box_fill_idx[9:8]] = 1'b1;
                    box_wa[box_fill_idx[9:8]] = box_fill_idx[7:0];
                    box_wd[box_fill_idx[9:8]] = r_reg;
                end
            end
            default: ;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    // key store: registered read, the read data always holds key_mem[pos_reg]
    // while the XOR pass runs
    assign pos_next = (6'(pos_reg) + 6'd1 < item_reg.key_length)
                      ? pos_reg + KP_W'(1) : '0;
    assign key_ra = (state_reg == S_XOR) ? pos_next : '0;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR && clr_reg < 8'(KEY_MAX_BYTES))
            key_mem[clr_reg[KP_W-1:0]] <= 8'h0;
        else if (state_reg == S_IDLE && in_valid && in_ready
                 && in_data.kind == KIND_KEY_BYTE
                 && in_data.index < 10'(KEY_MAX_BYTES))
            key_mem[in_data.index[KP_W-1:0]] <= in_data.key_byte;
        key_rd_reg <= key_mem[key_ra];
    end

    logic [31:0] wbyte_next;
    assign wbyte_next = {w_reg[23:0], key_rd_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:  if (clr_reg == 8'hFF) state_next = S_IDLE;
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (in_data.kind == KIND_BLOCK)
                        state_next = S_RREAD;
                    else if (in_data.kind == KIND_EXPAND && in_data.key_length != 6'd0
                             && in_data.key_length <= 6'(KEY_MAX_BYTES))
                        state_next = S_XOR;
                end
            end
            S_XOR:
            begin
                if (kb_reg == 2'd3 && ski_reg == SK_W'(SUBKEY_COUNT - 1))
                    state_next = S_RREAD;
            end
            S_RREAD:  state_next = S_RCOMB;
            S_RCOMB:
                state_next = (round_reg == 5'(ROUNDS - 1)) ? S_FINAL : S_RREAD;
            S_FINAL:  state_next = expand_reg ? S_STORE : S_OUT;
            S_STORE:  state_next = S_STORE2;
            S_STORE2:
                state_next = (fill_reg == 11'(SUBKEY_COUNT + BOX_WORDS - 1)) ? S_OUT
                                                                          : S_RREAD;
            S_OUT:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= 8'h0;
            out_valid_reg <= 1'b0;
            expand_reg    <= 1'b0;
            for (int i = 0; i < SUBKEY_COUNT; i++)
                subkey_reg[i] <= pi_word(5'(i));
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR: clr_reg <= clr_reg + 8'd1;
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        item_reg   <= in_data;
                        // expansion encrypts from a zero block
                        l_reg      <= (in_data.kind == KIND_EXPAND) ? 32'h0
                                                                    : in_data.left_in;
                        r_reg      <= (in_data.kind == KIND_EXPAND) ? 32'h0
                                                                    : in_data.right_in;
                        round_reg  <= 5'd0;
                        ski_reg    <= '0;
                        kb_reg     <= 2'd0;
                        pos_reg    <= '0;
                        w_reg      <= 32'h0;
                        fill_reg   <= 11'd0;
                        expand_reg <= (in_data.kind == KIND_EXPAND);
                        out_reg.left_out  <= 32'h0;
                        out_reg.right_out <= 32'h0;
                        case (in_data.kind)
                            KIND_LOAD_SUBKEY:
                            begin
                                if (in_data.index < 10'(SUBKEY_COUNT))
                                begin
                                    subkey_reg[in_data.index[SK_W-1:0]] <=
                                        in_data.table_word;
                                    out_reg.status <= STATUS_OK;
                                end
                                else
                                    out_reg.status <= STATUS_BAD_IDX;
                                out_valid_reg <= 1'b1;
                            end
                            KIND_KEY_BYTE:
                            begin
                                if (in_data.index < 10'(KEY_MAX_BYTES))
                                    out_reg.status <= STATUS_OK;
                                else
                                    out_reg.status <= STATUS_BAD_IDX;
                                out_valid_reg <= 1'b1;
                            end
                            KIND_EXPAND:
                            begin
                                if (in_data.key_length == 6'd0 ||
                                    in_data.key_length > 6'(KEY_MAX_BYTES))
                                begin
                                    out_reg.status <= STATUS_BAD_LEN;
                                    out_valid_reg  <= 1'b1;
                                end
                                else
                                    out_reg.status <= STATUS_OK;
                            end
                            KIND_BLOCK: out_reg.status <= STATUS_OK;
                            default:
                            begin
                                out_reg.status <= STATUS_OK;
                                out_valid_reg  <= 1'b1;
                            end
                        endcase
                    end
                end
                S_XOR:
                begin
                    w_reg <= wbyte_next;
                    pos_reg <= pos_next;
                    kb_reg <= kb_reg + 2'd1;
                    if (kb_reg == 2'd3)
                    begin
                        subkey_reg[ski_reg] <= subkey_reg[ski_reg] ^ wbyte_next;
                        ski_reg <= ski_reg + SK_W'(1);
                    end
                end
                S_RREAD: l_reg <= lx;
                S_RCOMB:
                begin
                    // swap halves after mixing F into right
                    l_reg     <= r_reg ^ f_val;
                    r_reg     <= l_reg;
                    round_reg <= round_reg + 5'd1;
                end
                S_FINAL:
                begin
                    round_reg <= 5'd0;
                    if (item_reg.decrypt_mode && !expand_reg)
                    begin
                        l_reg <= r_reg ^ subkey_reg[0];
                        r_reg <= l_reg ^ subkey_reg[1];
                        out_reg.left_out  <= r_reg ^ subkey_reg[0];
                        out_reg.right_out <= l_reg ^ subkey_reg[1];
                    end
                    else
                    begin
                        l_reg <= r_reg ^ subkey_reg[ROUNDS + 1];
                        r_reg <= l_reg ^ subkey_reg[ROUNDS];
                        out_reg.left_out  <= r_reg ^ subkey_reg[ROUNDS + 1];
                        out_reg.right_out <= l_reg ^ subkey_reg[ROUNDS];
                    end
                end
                S_STORE:
                begin
                    if (fill_reg < 11'(SUBKEY_COUNT))
                        subkey_reg[fill_reg[SK_W-1:0]] <= l_reg;
                    fill_reg <= fill_reg + 11'd1;
                end
                S_STORE2:
                begin
                    if (fill_reg < 11'(SUBKEY_COUNT))
                        subkey_reg[fill_reg[SK_W-1:0]] <= r_reg;
                    fill_reg <= fill_reg + 11'd1;
                end
                S_OUT:
                begin
                    if (expand_reg)
                        out_reg <= '0;
                    out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule
